// File: design/mpspwm_pkg.sv
// Shared types and constants for the multi-pin soft PWM generator.
// No dependencies; imported by the prescaler, the top level and the checker.
`default_nettype none

package mpspwm_pkg;

  localparam int DATA_W  = 16;  // pin words, duty, pin mask
  localparam int FREQ_W  = 16;  // tone frequency register
  localparam int STEP_W  = 8;   // reported step index
  localparam int PINS_MAX = 16;

  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1000);

  typedef enum logic [0:0] {
    ACT_TICK     = 1'b0,
    ACT_SET_DUTY = 1'b1
  } action_e;

endpackage

`default_nettype wire

// File: design/mpspwm_presc.sv
// Prescaler for the soft PWM generator: decides on which tick the step advances.
// Depends on mpspwm_pkg. Keeps count*freq so no divider is needed.
`default_nettype none

module mpspwm_presc import mpspwm_pkg::*; #(
  parameter int STEP_COUNT = 256,
  parameter int TICK_RATE  = 72000000
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [FREQ_W-1:0] cfg_wdata_i,
  input  wire logic              advance_i,
  output logic                   wrap_o
);

  // Wrap when count >= max(T/(S*f),1)-1, i.e. when (count+2)*f > floor(T/S).
  localparam int TS    = TICK_RATE / STEP_COUNT;
  localparam int CNT_W = ($clog2(TS + 1) > 0) ? $clog2(TS + 1) : 1;
  localparam int QW    = CNT_W + FREQ_W;
  localparam logic [QW:0] TS_V = (QW+1)'(TS);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [QW-1:0]     prod_q, prod_d;   // cnt_q * freq_q
  logic [FREQ_W-1:0] freq_q, freq_d;
  logic [FREQ_W-1:0] freq_new;
  logic [QW:0]       lhs;

  assign freq_new = (cfg_wdata_i == '0) ? FREQ_W'(1) : cfg_wdata_i;
  assign lhs      = {1'b0, prod_q} + (QW+1)'({freq_q, 1'b0});
  assign wrap_o   = lhs > TS_V;

  always_comb begin
    cnt_d  = cnt_q;
    prod_d = prod_q;
    freq_d = freq_q;
    if (cfg_we_i) begin
      freq_d = freq_new;
      // rescale the running product to the new frequency
      prod_d = QW'(cnt_q) * QW'(freq_new);
    end else if (advance_i) begin
      if (wrap_o) begin
        cnt_d  = '0;
        prod_d = '0;
      end else begin
        cnt_d  = cnt_q + 1'b1;
        prod_d = prod_q + QW'(freq_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prod_q <= '0;
      freq_q <= FREQ_RESET;
    end else begin
      cnt_q  <= cnt_d;
      prod_q <= prod_d;
      freq_q <= freq_d;
    end
  end

endmodule

`default_nettype wire

// File: design/multi_pin_soft_pwm_generator_top.sv
// Multi-pin soft PWM generator: up to sixteen pins sharing one step counter.
// Depends on mpspwm_pkg and mpspwm_presc.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per transfer:
//   a timer tick (action 0) or a set-duty request (action 1) with pin mask,
//   duty and port flag. Every item yields exactly one result transfer on the
//   output channel (out_valid_o / out_stall_i).
//   A tick that wraps the prescaler returns the set/reset word for the current
//   step and advances the step; other ticks return an all-zero result.
//   A set-duty request returns accepted = port flag and updates the pins only
//   when the flag is set.
//   The result appears in the cycle after its input transfer. One item is taken every
//   cycle unless a held result is stalled; the single output register decides the rate.
//   While the output register holds a result and the receiver stalls,
//   in_stall_o is high and nothing is taken.
//   Reset clears all pins to inactive, the prescaler and step to zero and the
//   tone frequency to 1000 Hz. cfg_we_i / cfg_wdata_i write the tone frequency;
//   write it only while no transfer is outstanding.
`default_nettype none

module multi_pin_soft_pwm_generator_top import mpspwm_pkg::*; #(
  parameter int STEP_COUNT = 256,
  parameter int TICK_RATE  = 72000000,
  parameter int PIN_COUNT  = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic [FREQ_W-1:0] cfg_wdata_i,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              action_i,
  input  wire logic [DATA_W-1:0] pin_mask_i,
  input  wire logic [DATA_W-1:0] duty_i,
  input  wire logic              target_is_port_a_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   write_valid_o,
  output logic [DATA_W-1:0]      set_bits_o,
  output logic [DATA_W-1:0]      reset_bits_o,
  output logic [STEP_W-1:0]      current_step_o,
  output logic                   accepted_o
);

  localparam int SW = ($clog2(STEP_COUNT) > 0) ? $clog2(STEP_COUNT) : 1;
  localparam logic [SW-1:0] STEP_LAST = SW'(STEP_COUNT - 1);

  logic              in_xfer;
  logic              is_set;
  logic              tick;
  logic              wrap;
  logic              emit;
  logic [SW-1:0]     step_q;
  logic [DATA_W-1:0] step_ext;
  logic [DATA_W-1:0] set_w, rst_w;

  logic [DATA_W-1:0] duty_q [PIN_COUNT];
  logic [PIN_COUNT-1:0] active_q;

  logic              out_valid_q;
  logic              write_valid_q;
  logic [DATA_W-1:0] set_q, rst_q;
  logic [STEP_W-1:0] step_out_q;
  logic              accepted_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign is_set     = (action_e'(action_i) == ACT_SET_DUTY);
  assign tick       = in_xfer & ~is_set;
  assign emit       = tick & wrap;
  assign step_ext   = DATA_W'(step_q);

  mpspwm_presc #(
    .STEP_COUNT (STEP_COUNT),
    .TICK_RATE  (TICK_RATE)
  ) u_presc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (tick),
    .wrap_o      (wrap)
  );

  // step word: inactive pins stay out of both words
  always_comb begin
    set_w = '0;
    rst_w = '0;
    for (int p = 0; p < PIN_COUNT; p++) begin
      set_w[p] = active_q[p] & (step_ext < duty_q[p]);
      rst_w[p] = active_q[p] & ~(step_ext < duty_q[p]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (in_xfer && is_set && target_is_port_a_i) begin
      for (int p = 0; p < PIN_COUNT; p++) begin
        if (pin_mask_i[p]) begin
          active_q[p] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && is_set && target_is_port_a_i) begin
      for (int p = 0; p < PIN_COUNT; p++) begin
        if (pin_mask_i[p]) begin
          duty_q[p] <= duty_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (emit) begin
      step_q <= (step_q == STEP_LAST) ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      write_valid_q <= emit;
      set_q         <= emit ? set_w : '0;
      rst_q         <= emit ? rst_w : '0;
      step_out_q    <= emit ? step_ext[STEP_W-1:0] : '0;
      accepted_q    <= is_set & target_is_port_a_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_valid_o  = write_valid_q;
  assign set_bits_o     = set_q;
  assign reset_bits_o   = rst_q;
  assign current_step_o = step_out_q;
  assign accepted_o     = accepted_q;

endmodule

`default_nettype wire

// File: design/mpspwm_chk.sv
// Port-level checker for the soft PWM generator, bound to the top level.
// Depends on mpspwm_pkg.
`default_nettype none

module mpspwm_chk import mpspwm_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              action_i,
  input wire logic              target_is_port_a_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              write_valid_o,
  input wire logic [DATA_W-1:0] set_bits_o,
  input wire logic [DATA_W-1:0] reset_bits_o,
  input wire logic [STEP_W-1:0] current_step_o,
  input wire logic              accepted_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i & ~in_stall_o;

  // set-duty transfer shows its verdict on the next cycle
  a_set_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && action_i == ACT_SET_DUTY |=>
      out_valid_o && accepted_o == $past(target_is_port_a_i) && !write_valid_o)
    else $error("set-duty result wrong");

  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && action_i == ACT_TICK |=> out_valid_o && !accepted_o)
    else $error("tick result wrong");

  a_quiet_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |->
      set_bits_o == '0 && reset_bits_o == '0 && current_step_o == '0)
    else $error("word without write_valid");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(set_bits_o)
      && $stable(reset_bits_o) && $stable(current_step_o))
    else $error("stalled result changed");

endmodule

bind multi_pin_soft_pwm_generator_top mpspwm_chk u_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .action_i           (action_i),
  .target_is_port_a_i (target_is_port_a_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .write_valid_o      (write_valid_o),
  .set_bits_o         (set_bits_o),
  .reset_bits_o       (reset_bits_o),
  .current_step_o     (current_step_o),
  .accepted_o         (accepted_o)
);

`default_nettype wire
